/* src/pknorm_pkg.sv */
// Package: widths, constants, divider request/response types and helpers for the peak normalizer.
`default_nettype none

package pknorm_pkg;

	localparam int MAX_SAMPLES = 64;
	localparam int SAMPLE_W    = 24;
	localparam int MINPK_W     = 23;
	localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
	localparam int ADDR_W      = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int DIV_STEPS   = SAMPLE_W;
	localparam int STEP_W      = $clog2(DIV_STEPS + 1);

	localparam logic [MINPK_W-1:0]  MIN_PEAK_RST = MINPK_W'(8);
	localparam logic [SAMPLE_W-1:0] POS_MAX      = {1'b0, {(SAMPLE_W-1){1'b1}}};

	typedef struct packed {
		logic                start;
		logic [SAMPLE_W-1:0] mag;
		logic [SAMPLE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                busy;
		logic                done;
		logic [SAMPLE_W-1:0] quot;
	} div_rsp_t;

	// |x| of a two's complement word, as unsigned; the most negative value maps to 2^23
	function automatic logic [SAMPLE_W-1:0] magnitude(input logic [SAMPLE_W-1:0] x);
		logic [SAMPLE_W-1:0] r;
		r = x[SAMPLE_W-1] ? (~x + 1'b1) : x;
		return r;
	endfunction

endpackage

`default_nettype wire

/* src/pknorm_ifs.sv */
// Interfaces: sample stream, result stream and min_peak write channel.
`default_nettype none

interface pknorm_sample_if;
	logic                                valid;
	logic                                ready;
	logic signed [pknorm_pkg::SAMPLE_W-1:0] sample;
	logic                                last_sample;

	modport source (output valid, output sample, output last_sample, input ready);
	modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface pknorm_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [pknorm_pkg::SAMPLE_W-1:0] scaled;
	logic                                last_out;

	modport source (output valid, output scaled, output last_out, input ready);
	modport sink   (input valid, input scaled, input last_out, output ready);
endinterface

interface pknorm_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [pknorm_pkg::MINPK_W-1:0]   min_peak;

	modport source (output valid, output min_peak, input ready);
	modport sink   (input valid, input min_peak, output ready);
endinterface

`default_nettype wire

/* src/pknorm_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module pknorm_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 24,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* src/pknorm_div.sv */
// Radix-2 restoring divider: quot = mag * 2^23 / divisor, one quotient bit per cycle.
`default_nettype none

module pknorm_div (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire pknorm_pkg::div_req_t req,
	output pknorm_pkg::div_rsp_t      rsp
);

	import pknorm_pkg::*;

	logic [SAMPLE_W-1:0] rem_q;
	logic [SAMPLE_W-1:0] lo_q;
	logic [SAMPLE_W-1:0] quot_q;
	logic [SAMPLE_W-1:0] div_q;
	logic [STEP_W-1:0]   step_q;
	logic                busy_q;
	logic                done_q;

	logic [SAMPLE_W:0]   trial;
	logic                fits;
	logic [SAMPLE_W:0]   diff;

	// dividend is {mag, 23'b0}; its top bits (mag >> 1) are already below divisor
	assign trial = {rem_q, lo_q[SAMPLE_W-1]};
	assign fits  = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= STEP_W'(DIV_STEPS);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= {1'b0, req.mag[SAMPLE_W-1:1]};
			lo_q   <= {req.mag[0], {(SAMPLE_W-1){1'b0}}};
			div_q  <= req.divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
			lo_q   <= {lo_q[SAMPLE_W-2:0], 1'b0};
			quot_q <= {quot_q[SAMPLE_W-2:0], fits};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

`default_nettype wire

/* src/peak_normalizer_top.sv */
// Top level: sample store, peak tracking, flush sequencer and output register.
// Load: one word per cycle; the closing word is taken at once and the flush starts next cycle.
// Flush: each result when scaling goes through RAM read, fetch, 24-step divider and load;
// when the block passes unscaled, it goes through RAM read, fetch and load, with no divider.
// Input is not taken during a flush; the output register lets the next block load while
// the final result waits. Reset clears control state and sets min_peak to 8; no RAM clear.
`default_nettype none

module peak_normalizer_top (
	input  wire logic      clk,
	input  wire logic      arst_n,
	pknorm_sample_if.sink  sample_ch,
	pknorm_result_if.source result_ch,
	pknorm_cfg_if.sink     cfg_ch
);

	import pknorm_pkg::*;

	typedef enum logic [3:0] {
		S_LOAD  = 4'b0001,  // taking samples
		S_READ  = 4'b0010,  // RAM read issued
		S_FETCH = 4'b0100,  // read data back, divider launched when scaling
		S_DIV   = 4'b1000   // waiting on quotient / output slot
	} state_t;

	state_t              state_q;
	logic [MINPK_W-1:0]  min_peak_q;
	logic [CNT_W-1:0]    cnt_q;      // samples stored in the current block
	logic [CNT_W-1:0]    total_q;    // samples to flush
	logic [CNT_W-1:0]    idx_q;      // flush position
	logic [SAMPLE_W-1:0] peak_q;
	logic [SAMPLE_W-1:0] divisor_q;  // frozen peak for the flush
	logic                do_scale_q;
	logic [SAMPLE_W-1:0] raw_q;
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] scaled_q;
	logic                last_q;

	logic                in_acc;
	logic                not_full;
	logic [SAMPLE_W-1:0] in_mag;
	logic [SAMPLE_W-1:0] peak_next;
	logic [CNT_W-1:0]    cnt_next;
	logic                ram_we;
	logic                ram_re;
	logic [SAMPLE_W-1:0] ram_rdata;
	div_req_t            div_req;
	div_rsp_t            div_rsp;
	logic                res_load;
	logic                res_last;
	logic [SAMPLE_W-1:0] res_val;
	logic [SAMPLE_W-1:0] quot_neg;

	// ---- config: always ready; the user must write it only while idle, the block does not enforce it
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_peak_q <= MIN_PEAK_RST;
		end else if (cfg_ch.valid) begin
			min_peak_q <= cfg_ch.min_peak;
		end
	end

	// ---- load side
	assign sample_ch.ready = (state_q == S_LOAD);
	assign in_acc    = sample_ch.valid && sample_ch.ready;
	// once the store is full, later words (closing one too) are dropped from store and peak
	assign not_full  = cnt_q < CNT_W'(MAX_SAMPLES);
	assign in_mag    = magnitude(sample_ch.sample);
	assign peak_next = (not_full && (in_mag > peak_q)) ? in_mag : peak_q;
	assign cnt_next  = not_full ? cnt_q + 1'b1 : cnt_q;
	assign ram_we    = in_acc && not_full;

	// ---- flush side
	assign ram_re = (state_q == S_READ);

	pknorm_ram #(
		.DEPTH (MAX_SAMPLES),
		.WIDTH (SAMPLE_W),
		.AW    (ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[ADDR_W-1:0]),
		.wdata (sample_ch.sample),
		.re    (ram_re),
		.raddr (idx_q[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	assign div_req.start   = (state_q == S_FETCH) && do_scale_q;
	assign div_req.mag     = magnitude(ram_rdata);
	assign div_req.divisor = divisor_q;

	pknorm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// sample equal to +peak gives 2^23: saturate; -peak wraps to -2^23, which is exact
	assign quot_neg = ~div_rsp.quot + 1'b1;
	always_comb begin
		if (!do_scale_q) begin
			res_val = raw_q;
		end else if (raw_q[SAMPLE_W-1]) begin
			res_val = quot_neg;
		end else if (div_rsp.quot[SAMPLE_W-1]) begin
			res_val = POS_MAX;
		end else begin
			res_val = div_rsp.quot;
		end
	end

	assign res_last = (idx_q + 1'b1) == total_q;
	assign res_load = (state_q == S_DIV) && (!do_scale_q || div_rsp.done)
	                  && (!out_valid_q || result_ch.ready);

	// ---- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			cnt_q      <= '0;
			total_q    <= '0;
			idx_q      <= '0;
			peak_q     <= '0;
			do_scale_q <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (sample_ch.last_sample) begin
							total_q    <= cnt_next;
							do_scale_q <= (peak_next >= {1'b0, min_peak_q}) && (peak_next != '0);
							cnt_q      <= '0;
							peak_q     <= '0;
							idx_q      <= '0;
							state_q    <= S_READ;
						end else begin
							cnt_q  <= cnt_next;
							peak_q <= peak_next;
						end
					end
				end
				S_READ: begin
					state_q <= S_FETCH;
				end
				S_FETCH: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (res_load) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= res_last ? S_LOAD : S_READ;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// frozen divisor and fetched word; payload, no reset
	always_ff @(posedge clk) begin
		if (in_acc && sample_ch.last_sample) begin
			divisor_q <= peak_next;
		end
		if (state_q == S_FETCH) begin
			raw_q <= ram_rdata;
		end
	end

	// ---- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			scaled_q <= res_val;
			last_q   <= res_last;
		end
	end

	assign result_ch.valid    = out_valid_q;
	assign result_ch.scaled   = scaled_q;
	assign result_ch.last_out = last_q;

	// ---- checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_SAMPLES))
		else $error("store count past capacity");

	a_flush_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_LOAD) |-> (idx_q < total_q))
		else $error("flush index beyond stored count");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && res_last) |=> (state_q == S_LOAD))
		else $error("flush did not end on final result");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider launched while busy");

	a_nonzero_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> (divisor_q != '0))
		else $error("divide by zero peak");

endmodule

`default_nettype wire
